FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define WRBT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("windowed_byte_rate_throttle: assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define WRBT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("windowed_byte_rate_throttle: assertion failed");

`endif

FILE: hw/rtl/wrbt_pkg.sv
// Types, constants and helper functions of the windowed byte rate throttle.
`default_nettype none

package wrbt_pkg;

    localparam int NOW_W      = 42;
    localparam int REC_W      = 25;
    localparam int LIMIT_W    = 16;
    localparam int SLEEP_W    = 16;
    localparam int RATE_W     = 32;
    localparam int WBYTES_W   = 48;
    localparam int TBYTES_W   = 56;
    localparam int TMS_W      = 42;
    localparam int WINDOW_W   = 16;

    localparam int unsigned WINDOW_MS_DEFAULT = 1000;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT        = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_OFF = 1'd1;

    // One MB is 2^20 bytes; a rate in 1/256 MB/s from bytes and ms is
    // bytes * 125 / (ms * 512).
    localparam int LIMIT_SHIFT = 20;
    localparam int MS_SHIFT    = 9;
    localparam int LIMIT_BYTES_W = LIMIT_W + LIMIT_SHIFT;

    localparam int DIV_NUM_W = 63;
    localparam int DIV_DEN_W = 51;

    typedef enum logic [1:0] {
        DIV_SEL_WIN  = 2'd0,
        DIV_SEL_AVG  = 2'd1,
        DIV_SEL_WAIT = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     capture;
        logic     check;
        logic     div_start;
        div_sel_t div_sel;
        logic     store_win;
        logic     store_avg;
        logic     add_rec;
        logic     store_sleep;
        logic     clear_sleep;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic roll;
        logic div_done;
        logic wait_needed;
        logic out_full;
    } dp_status_t;

    function automatic logic [RATE_W-1:0] sat_rate(input logic [DIV_NUM_W-1:0] q);
        logic [RATE_W-1:0] r;
        r = (|q[DIV_NUM_W-1:RATE_W]) ? {RATE_W{1'b1}} : q[RATE_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wrbt_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
`default_nettype none

module wrbt_div
    import wrbt_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;

    logic [DEN_W:0] partial;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb
    begin
        partial = {rem_reg, num_reg[NUM_W-1]};
        diff    = partial - {1'b0, den_reg};
        ge      = partial >= {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
            num_next = {num_reg[NUM_W-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/wrbt_datapath.sv
// Datapath: window and lifetime counters, rate and wait arithmetic, output register.
`default_nettype none

module wrbt_datapath
    import wrbt_pkg::*;
#(
    parameter int unsigned WINDOW_MS = WINDOW_MS_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dp_cmd_t                cmd,
    output dp_status_t                  status,
    input  wire logic                   cfg_beat,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [NOW_W-1:0]       now_ms,
    input  wire logic [REC_W-1:0]       record_bytes,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic      [SLEEP_W-1:0]     sleep_ms,
    output logic                        window_rolled,
    output logic      [RATE_W-1:0]      last_rate,
    output logic      [RATE_W-1:0]      average_rate
);

    function automatic logic [DIV_NUM_W-1:0] mul125(input logic [DIV_NUM_W-1:0] x);
        return (x << 7) - (x << 1) - x;
    endfunction

    function automatic logic [DIV_NUM_W-1:0] mul1000(input logic [DIV_NUM_W-1:0] x);
        return (x << 10) - (x << 4) - (x << 3);
    endfunction

    // Configuration.
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               off_reg, off_next;

    // Architectural state.
    logic [NOW_W-1:0]    window_start_reg, window_start_next;
    logic [WBYTES_W-1:0] window_bytes_reg, window_bytes_next;
    logic [TBYTES_W-1:0] total_bytes_reg, total_bytes_next;
    logic [TMS_W-1:0]    total_ms_reg, total_ms_next;
    logic [RATE_W-1:0]   last_rate_reg, last_rate_next;
    logic [RATE_W-1:0]   avg_rate_reg, avg_rate_next;
    logic                out_valid_reg, out_valid_next;

    // Working registers of one item.
    logic [NOW_W-1:0]    now_reg, now_next;
    logic [REC_W-1:0]    rec_reg, rec_next;
    logic [WBYTES_W-1:0] wb_sum_reg, wb_sum_next;
    logic [NOW_W-1:0]    elapsed_reg, elapsed_next;
    logic                rolled_reg, rolled_next;
    logic [SLEEP_W-1:0]  sleep_reg, sleep_next;

    // Output register.
    logic [SLEEP_W-1:0] sleep_out_reg, sleep_out_next;
    logic               rolled_out_reg, rolled_out_next;
    logic [RATE_W-1:0]  last_out_reg, last_out_next;
    logic [RATE_W-1:0]  avg_out_reg, avg_out_next;

    logic                     roll;
    logic [WBYTES_W:0]        wb_add;
    logic [WBYTES_W-1:0]      wb_sat;
    logic [WBYTES_W:0]        wr_add;
    logic [WBYTES_W-1:0]      wr_sat;
    logic [TBYTES_W:0]        tb_add;
    logic [TMS_W:0]           tm_add;
    logic [LIMIT_BYTES_W-1:0] limit_bytes;
    logic                     wait_needed;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIV_DEN_W-1:0]     div_den;
    logic                     div_done;
    logic [DIV_NUM_W-1:0]     quotient;
    logic [DIV_NUM_W-1:0]     wait_excess;
    logic                     wait_over;

    always_comb
    begin
        roll = {1'b0, now_reg} >= ({1'b0, window_start_reg} + (NOW_W + 1)'(WINDOW_MS));

        wb_add = {1'b0, window_bytes_reg} + (WBYTES_W + 1)'(rec_reg);
        wb_sat = wb_add[WBYTES_W] ? {WBYTES_W{1'b1}} : wb_add[WBYTES_W-1:0];
        wr_add = {1'b0, window_bytes_reg} + (WBYTES_W + 1)'(rec_reg);
        wr_sat = wr_add[WBYTES_W] ? {WBYTES_W{1'b1}} : wr_add[WBYTES_W-1:0];

        tb_add = {1'b0, total_bytes_reg} + (TBYTES_W + 1)'(wb_sum_reg);
        tm_add = {1'b0, total_ms_reg} + (TMS_W + 1)'(elapsed_reg);

        limit_bytes = {limit_reg, {LIMIT_SHIFT{1'b0}}};
        wait_needed = !off_reg && (limit_reg != '0)
                      && (window_bytes_reg >= WBYTES_W'(limit_bytes));

        case (cmd.div_sel)
            DIV_SEL_WIN:
            begin
                div_num = mul125(DIV_NUM_W'(wb_sum_reg));
                div_den = DIV_DEN_W'(elapsed_reg) << MS_SHIFT;
            end
            DIV_SEL_AVG:
            begin
                div_num = mul125(DIV_NUM_W'(total_bytes_reg));
                div_den = DIV_DEN_W'(total_ms_reg) << MS_SHIFT;
            end
            DIV_SEL_WAIT:
            begin
                div_num = mul1000(DIV_NUM_W'(window_bytes_reg));
                div_den = DIV_DEN_W'(limit_bytes);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase

        wait_over   = quotient > DIV_NUM_W'(elapsed_reg);
        wait_excess = quotient - DIV_NUM_W'(elapsed_reg);
    end

    wrbt_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        limit_next        = limit_reg;
        off_next          = off_reg;
        window_start_next = window_start_reg;
        window_bytes_next = window_bytes_reg;
        total_bytes_next  = total_bytes_reg;
        total_ms_next     = total_ms_reg;
        last_rate_next    = last_rate_reg;
        avg_rate_next     = avg_rate_reg;
        now_next          = now_reg;
        rec_next          = rec_reg;
        wb_sum_next       = wb_sum_reg;
        elapsed_next      = elapsed_reg;
        rolled_next       = rolled_reg;
        sleep_next        = sleep_reg;
        sleep_out_next    = sleep_out_reg;
        rolled_out_next   = rolled_out_reg;
        last_out_next     = last_out_reg;
        avg_out_next      = avg_out_reg;
        out_valid_next    = out_valid_reg;

        if (cfg_beat)
        begin
            case (cfg_index)
                REG_LIMIT:        limit_next = cfg_data;
                REG_THROTTLE_OFF: off_next   = cfg_data[0];
                default:          limit_next = limit_reg;
            endcase
        end

        if (cmd.capture)
        begin
            now_next = now_ms;
            rec_next = record_bytes;
        end

        if (cmd.check)
        begin
            rolled_next  = roll;
            wb_sum_next  = wb_sat;
            elapsed_next = now_reg - window_start_reg;
        end

        if (cmd.store_win)
        begin
            last_rate_next    = sat_rate(quotient);
            total_bytes_next  = tb_add[TBYTES_W] ? {TBYTES_W{1'b1}} : tb_add[TBYTES_W-1:0];
            total_ms_next     = tm_add[TMS_W] ? {TMS_W{1'b1}} : tm_add[TMS_W-1:0];
            window_start_next = now_reg;
            window_bytes_next = '0;
        end

        if (cmd.store_avg)
        begin
            avg_rate_next = sat_rate(quotient);
        end

        // The window count grows here; elapsed now measures from the window start
        // as it stands after any close, and counts as zero when the clock is behind.
        if (cmd.add_rec)
        begin
            window_bytes_next = wr_sat;
            elapsed_next = (now_reg > window_start_reg) ? (now_reg - window_start_reg) : '0;
        end

        if (cmd.store_sleep)
        begin
            if (!wait_over)
            begin
                sleep_next = '0;
            end
            else if (|wait_excess[DIV_NUM_W-1:SLEEP_W])
            begin
                sleep_next = {SLEEP_W{1'b1}};
            end
            else
            begin
                sleep_next = wait_excess[SLEEP_W-1:0];
            end
        end

        if (cmd.clear_sleep)
        begin
            sleep_next = '0;
        end

        if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            sleep_out_next  = sleep_reg;
            rolled_out_next = rolled_reg;
            last_out_next   = last_rate_reg;
            avg_out_next    = avg_rate_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg        <= '0;
            off_reg          <= 1'b0;
            window_start_reg <= '0;
            window_bytes_reg <= '0;
            total_bytes_reg  <= '0;
            total_ms_reg     <= '0;
            last_rate_reg    <= '0;
            avg_rate_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            limit_reg        <= limit_next;
            off_reg          <= off_next;
            window_start_reg <= window_start_next;
            window_bytes_reg <= window_bytes_next;
            total_bytes_reg  <= total_bytes_next;
            total_ms_reg     <= total_ms_next;
            last_rate_reg    <= last_rate_next;
            avg_rate_reg     <= avg_rate_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        rec_reg        <= rec_next;
        wb_sum_reg     <= wb_sum_next;
        elapsed_reg    <= elapsed_next;
        rolled_reg     <= rolled_next;
        sleep_reg      <= sleep_next;
        sleep_out_reg  <= sleep_out_next;
        rolled_out_reg <= rolled_out_next;
        last_out_reg   <= last_out_next;
        avg_out_reg    <= avg_out_next;
    end

    always_comb
    begin
        status.roll        = roll;
        status.div_done    = div_done;
        status.wait_needed = wait_needed;
        status.out_full    = out_valid_reg && !out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign sleep_ms      = sleep_out_reg;
    assign window_rolled = rolled_out_reg;
    assign last_rate     = last_out_reg;
    assign average_rate  = avg_out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/wrbt_ctrl.sv
// Controller state machine that sequences one record through the datapath.
`default_nettype none

module wrbt_ctrl
    import wrbt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_CHECK     = 10'b00_0000_0010,
        ST_WIN_START = 10'b00_0000_0100,
        ST_WIN_DIV   = 10'b00_0000_1000,
        ST_AVG_START = 10'b00_0001_0000,
        ST_AVG_DIV   = 10'b00_0010_0000,
        ST_ADD       = 10'b00_0100_0000,
        ST_TEST      = 10'b00_1000_0000,
        ST_WAIT_DIV  = 10'b01_0000_0000,
        ST_FINISH    = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_SEL_WIN;
        in_ready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.roll ? ST_WIN_START : ST_ADD;
            end
            ST_WIN_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_WIN;
                state_next    = ST_WIN_DIV;
            end
            ST_WIN_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.store_win = 1'b1;
                    state_next    = ST_AVG_START;
                end
            end
            ST_AVG_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_AVG;
                state_next    = ST_AVG_DIV;
            end
            ST_AVG_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.store_avg = 1'b1;
                    state_next    = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.add_rec = 1'b1;
                state_next  = ST_TEST;
            end
            ST_TEST:
            begin
                if (status.wait_needed)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_WAIT;
                    state_next    = ST_WAIT_DIV;
                end
                else
                begin
                    cmd.clear_sleep = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            ST_WAIT_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.store_sleep = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/windowed_byte_rate_throttle.sv
// Top level of the windowed byte rate throttle: controller, datapath and ports.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------
//   in      | sink      | in_valid / in_ready | now_ms, record_bytes
//   out     | source    | out_valid/out_ready | sleep_ms, window_rolled, last_rate,
//           |           |                     | average_rate
//   cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A record with no window close and no wait due steps through the check, add, test and
// finish states; the finish state loads its result beat into the output register and
// returns to idle. Closing a window adds two divisions and a wait adds one (it starts in
// the test state); the shared divider produces one quotient bit per cycle.
// Reset (rst_n low, asynchronous) clears all counters, rates and configuration to zero;
// no clearing pass is needed. A result beat that is not taken holds in the output register
// while the next record is accepted; that record stalls at its end only if the held beat
// is still waiting.
`default_nettype none

module windowed_byte_rate_throttle
    import wrbt_pkg::*;
#(
    // Window length in milliseconds, 1 to 65535.
    parameter int unsigned WINDOW_MS = WINDOW_MS_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [NOW_W-1:0]       now_ms,
    input  wire logic [REC_W-1:0]       record_bytes,

    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [SLEEP_W-1:0]     sleep_ms,
    output logic                        window_rolled,
    output logic      [RATE_W-1:0]      last_rate,
    output logic      [RATE_W-1:0]      average_rate,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_beat;

    // Configuration writes go straight into the configuration registers, so the port never stalls. Writes are
    // expected only while no record is in flight.
    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;

    // The controller steps a record through the check, close, add, wait and output phases
    // and issues one command word per cycle; the datapath answers with its status flags.
    wrbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the window and lifetime counters, the shared divider and the
    // output register that decouples the result beat from the next record.
    wrbt_datapath #(
        .WINDOW_MS (WINDOW_MS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_beat      (cfg_beat),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .now_ms        (now_ms),
        .record_bytes  (record_bytes),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .sleep_ms      (sleep_ms),
        .window_rolled (window_rolled),
        .last_rate     (last_rate),
        .average_rate  (average_rate)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/wrbt_checker.sv
// Port-level assertion checker for the windowed byte rate throttle, with its bind.
`default_nettype none

`include "assert_macros.svh"

module wrbt_checker
    import wrbt_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [SLEEP_W-1:0]     sleep_ms,
    input wire logic                   window_rolled,
    input wire logic [RATE_W-1:0]      last_rate,
    input wire logic [RATE_W-1:0]      average_rate
);

    logic       in_beat;
    logic       out_beat;
    logic [1:0] outstanding_reg, outstanding_next;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // Records accepted whose result beat has not yet been taken.
    always_comb
    begin
        outstanding_next = outstanding_reg + (in_beat ? 2'd1 : 2'd0) - (out_beat ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    `WRBT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sleep_ms) && $stable(window_rolled) && $stable(last_rate) && $stable(average_rate))
    `WRBT_ASSERT_IMP(a_no_invented_result, out_valid, outstanding_reg != 2'd0)
    `WRBT_ASSERT_IMP(a_at_most_two_in_flight, 1'b1, outstanding_reg != 2'd3)
    `WRBT_ASSERT_IMP(a_no_instant_result, $rose(out_valid), !$past(in_valid && in_ready))

endmodule

bind windowed_byte_rate_throttle wrbt_checker u_wrbt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sleep_ms      (sleep_ms),
    .window_rolled (window_rolled),
    .last_rate     (last_rate),
    .average_rate  (average_rate)
);

`default_nettype wire
